[src/gaussian_spotlight_pixel_blend_defines.svh]
`ifndef GAUSSIAN_SPOTLIGHT_PIXEL_BLEND_DEFINES_SVH
`define GAUSSIAN_SPOTLIGHT_PIXEL_BLEND_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define GSP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define GSP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/gsp_pkg.sv]
package gsp_pkg;

	localparam int CFG_BITS = 12;
	localparam int CH_BITS = 8;
	localparam int CH_MAX = 255;
	localparam int NUM_CH = 3;

	localparam int SPREAD = 50;
	localparam int GAIN = 3;
	localparam int FRAC_BITS = 8;

	// Exponent argument is Q4.8; anything at or above 16.0 gives zero weight.
	localparam int ARG_BITS = 12;
	localparam int DEN_W = 18;
	localparam int REM_W = DEN_W + ARG_BITS;

	localparam int ALPHA_BITS = 16;
	localparam int ALPHA_ONE = 1 << ALPHA_BITS;
	localparam int ALPHA_MAX = ALPHA_ONE - 1;
	localparam int ROUND_HALF = 1 << (ALPHA_BITS - 1);
	localparam int T_BITS = 20;

	localparam int AXIS_STAGES = 3 + ARG_BITS;
	localparam int MERGE_STAGES = 2;
	localparam int BLEND_STAGES = 2;
	localparam int PIX_STAGES = AXIS_STAGES + MERGE_STAGES;
	localparam int PIPE_STAGES = PIX_STAGES + BLEND_STAGES;

	localparam int CFG_IDX_BITS = 8;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_FACE_LEFT   = 8'd0,
		REG_FACE_TOP    = 8'd1,
		REG_FACE_WIDTH  = 8'd2,
		REG_FACE_HEIGHT = 8'd3
	} cfg_reg_t;

	typedef struct packed {
		logic                over;
		logic [ARG_BITS-1:0] term;
	} axis_res_t;

	// Channel 0 is blue, 1 green, 2 red.
	typedef struct packed {
		logic [NUM_CH-1:0][CH_BITS-1:0] color;
		logic [NUM_CH-1:0][CH_BITS-1:0] base;
	} pix_t;

endpackage

[src/gaussian_spotlight_pixel_blend.sv]
// Spotlight blend: each pixel word is mixed between its original color (with a gain of
// three) and its background color by a Gaussian weight of its distance to the center of
// the face rectangle held in the four configuration registers. The block takes one pixel
// word per clock while a stage is free or the output is ready; each result passes through
// the twelve-step pipelined divider in each axis lane, then the exponent table read and
// the two-stage channel blend. Every stage advances on its own, so the input keeps
// flowing while a finished word waits at the output until the pipeline is full.
// Configuration writes are always accepted and must only be issued while no pixel is in
// flight; an unknown register index is ignored.
`include "gaussian_spotlight_pixel_blend_defines.svh"

module gaussian_spotlight_pixel_blend import gsp_pkg::*; #(
	parameter int COORD_BITS = 12,
	parameter int EXP_TABLE_DEPTH = 1024
) (
	input  logic clk,
	input  logic arst_n,

	input  logic s_tvalid,
	output logic s_tready,
	// pixel_col, pixel_row, color_blue, color_green, color_red,
	// base_blue, base_green, base_red, zero fill to whole bytes
	input  logic [((2*COORD_BITS + 6*CH_BITS + 7) / 8) * 8 - 1:0] s_tdata,

	output logic m_tvalid,
	input  logic m_tready,
	// out_blue, out_green, out_red
	output logic [NUM_CH*CH_BITS-1:0] m_tdata,

	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [CFG_IDX_BITS-1:0] cfg_index,
	input  logic [CFG_BITS-1:0]     cfg_data
);

	localparam int CLR_LO = 2 * COORD_BITS;
	localparam int BASE_LO = CLR_LO + NUM_CH * CH_BITS;

	logic [CFG_BITS-1:0] face_left_q;
	logic [CFG_BITS-1:0] face_top_q;
	logic [CFG_BITS-1:0] face_width_q;
	logic [CFG_BITS-1:0] face_height_q;

	logic [PIPE_STAGES:1]   v_q;
	logic [PIPE_STAGES:1]   adv;
	pix_t                   pix_in;
	pix_t                   pix_s [1:PIX_STAGES];
	axis_res_t              res_x;
	axis_res_t              res_y;
	logic [ALPHA_BITS-1:0]  alpha;
	logic [NUM_CH-1:0][CH_BITS-1:0] out_ch;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			face_left_q   <= CFG_BITS'(0);
			face_top_q    <= CFG_BITS'(0);
			face_width_q  <= CFG_BITS'(30);
			face_height_q <= CFG_BITS'(30);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_FACE_LEFT:   face_left_q   <= cfg_data;
				REG_FACE_TOP:    face_top_q    <= cfg_data;
				REG_FACE_WIDTH:  face_width_q  <= cfg_data;
				REG_FACE_HEIGHT: face_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// A stage may move when the output is ready or any stage from it to the output is empty.
	for (genvar k = 1; k <= PIPE_STAGES; k++) begin : g_adv
		assign adv[k] = m_tready || !(&v_q[PIPE_STAGES:k]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k] <= 1'b0;
			end else if (adv[k]) begin
				if (k == 1) begin
					v_q[k] <= s_tvalid;
				end else begin
					v_q[k] <= v_q[(k > 1) ? k - 1 : 1];
				end
			end
		end
	end

	assign s_tready = adv[1];
	assign m_tvalid = v_q[PIPE_STAGES];

	always_comb begin
		for (int c = 0; c < NUM_CH; c++) begin
			pix_in.color[c] = s_tdata[CLR_LO + c*CH_BITS +: CH_BITS];
			pix_in.base[c]  = s_tdata[BASE_LO + c*CH_BITS +: CH_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			pix_s[1] <= pix_in;
		end
	end

	for (genvar k = 2; k <= PIX_STAGES; k++) begin : g_pix
		always_ff @(posedge clk) begin
			if (adv[k]) begin
				pix_s[k] <= pix_s[k-1];
			end
		end
	end

	gsp_axis_lane #(
		.COORD_BITS(COORD_BITS)
	) u_axis_x (
		.clk (clk),
		.en  (adv[AXIS_STAGES:1]),
		.pos (s_tdata[COORD_BITS-1:0]),
		.org (face_left_q),
		.size(face_width_q),
		.res (res_x)
	);

	gsp_axis_lane #(
		.COORD_BITS(COORD_BITS)
	) u_axis_y (
		.clk (clk),
		.en  (adv[AXIS_STAGES:1]),
		.pos (s_tdata[2*COORD_BITS-1:COORD_BITS]),
		.org (face_top_q),
		.size(face_height_q),
		.res (res_y)
	);

	gsp_alpha_merge #(
		.EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
	) u_merge (
		.clk  (clk),
		.en   (adv[PIX_STAGES:AXIS_STAGES+1]),
		.res_x(res_x),
		.res_y(res_y),
		.alpha(alpha)
	);

	for (genvar c = 0; c < NUM_CH; c++) begin : g_blend
		gsp_blend_lane u_blend (
			.clk   (clk),
			.en    (adv[PIPE_STAGES:PIX_STAGES+1]),
			.alpha (alpha),
			.color (pix_s[PIX_STAGES].color[c]),
			.base  (pix_s[PIX_STAGES].base[c]),
			.result(out_ch[c])
		);
	end

	assign m_tdata = out_ch;

	`GSP_ASSERT_SAME(a_ready_with_room, clk, arst_n, !(&v_q), s_tready, "input stalled with a free stage")
	`GSP_ASSERT_NEXT(a_fill_count_up, clk, arst_n, s_tvalid && s_tready && !(m_tvalid && m_tready), $countones(v_q) == $past($countones(v_q)) + 1, "accepted word not tracked")
	`GSP_ASSERT_NEXT(a_fill_count_down, clk, arst_n, !(s_tvalid && s_tready) && m_tvalid && m_tready, $countones(v_q) + 1 == $past($countones(v_q)), "delivered word not retired")

endmodule

[src/gsp_axis_lane.sv]
module gsp_axis_lane import gsp_pkg::*; #(
	parameter int COORD_BITS = 12
) (
	input  logic                   clk,
	input  logic [AXIS_STAGES-1:0] en,
	input  logic [COORD_BITS-1:0]  pos,
	input  logic [CFG_BITS-1:0]    org,
	input  logic [CFG_BITS-1:0]    size,
	output axis_res_t              res
);

	localparam int PW = ((COORD_BITS > CFG_BITS) ? COORD_BITS : CFG_BITS) + 1;
	localparam int NW = 2 * PW + FRAC_BITS;

	logic [CFG_BITS-1:0] size_eff;
	logic [PW-1:0]       ctr;
	logic [PW-1:0]       pos_x;
	logic [PW-1:0]       diff;
	logic [NW-1:0]       num;
	logic [NW-1:0]       lim;

	logic [PW-1:0]       dist_s1;
	logic [DEN_W-1:0]    den_s1;
	logic [2*PW-1:0]     sq_s2;
	logic [DEN_W-1:0]    den_s2;

	// Index 0 of these arrays is stage 3; each divide step adds one.
	logic [REM_W-1:0]    rem_s  [ARG_BITS];
	logic [DEN_W-1:0]    den_s  [ARG_BITS];
	logic [ARG_BITS-1:0] quo_s  [ARG_BITS+1];
	logic                over_s [ARG_BITS+1];

	assign size_eff = (size == '0) ? CFG_BITS'(1) : size;
	assign ctr      = PW'(org) + PW'(size_eff >> 1);
	assign pos_x    = PW'(pos);
	assign diff     = (pos_x >= ctr) ? (pos_x - ctr) : (ctr - pos_x);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			dist_s1 <= diff;
			den_s1  <= DEN_W'(size_eff) * DEN_W'(SPREAD);
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			sq_s2  <= (2*PW)'(dist_s1) * (2*PW)'(dist_s1);
			den_s2 <= den_s1;
		end
	end

	assign num = {sq_s2, FRAC_BITS'(0)};
	assign lim = NW'(den_s2) << ARG_BITS;

	// When the quotient would not fit, the term alone already gives zero weight.
	always_ff @(posedge clk) begin
		if (en[2]) begin
			over_s[0] <= (num >= lim);
			rem_s[0]  <= num[REM_W-1:0];
			den_s[0]  <= den_s2;
			quo_s[0]  <= '0;
		end
	end

	for (genvar i = 0; i < ARG_BITS; i++) begin : g_div
		localparam int SH = ARG_BITS - 1 - i;
		logic [REM_W-1:0] trial;
		logic             take;

		assign trial = REM_W'(den_s[i]) << SH;
		assign take  = (rem_s[i] >= trial);

		always_ff @(posedge clk) begin
			if (en[i+3]) begin
				quo_s[i+1]  <= take ? (quo_s[i] | (ARG_BITS'(1) << SH)) : quo_s[i];
				over_s[i+1] <= over_s[i];
			end
		end

		if (i < ARG_BITS - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (en[i+3]) begin
					rem_s[i+1] <= take ? (rem_s[i] - trial) : rem_s[i];
					den_s[i+1] <= den_s[i];
				end
			end
		end
	end

	assign res.over = over_s[ARG_BITS];
	assign res.term = quo_s[ARG_BITS];

endmodule

[src/gsp_alpha_merge.sv]
module gsp_alpha_merge import gsp_pkg::*; #(
	parameter int EXP_TABLE_DEPTH = 1024
) (
	input  logic                    clk,
	input  logic [MERGE_STAGES-1:0] en,
	input  axis_res_t               res_x,
	input  axis_res_t               res_y,
	output logic [ALPHA_BITS-1:0]   alpha
);

	localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);
	localparam int PROD_W = ARG_BITS + $clog2(EXP_TABLE_DEPTH + 1);

	typedef logic [ALPHA_BITS-1:0] rom_t [EXP_TABLE_DEPTH];

	// Entry i is exp(-t) with t in Q.16, built by repeated squaring in Q0.32.
	function automatic rom_t exp_rom_build();
		rom_t        tbl;
		logic [63:0] t;
		logic [63:0] c;
		logic [63:0] acc;
		logic [63:0] a;
		for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
			t = (64'(i) << T_BITS) / 64'(EXP_TABLE_DEPTH);
			c = 64'hFFFF_0000;
			acc = 64'd1 << 32;
			for (int b = 0; b < T_BITS; b++) begin
				if (t[b]) begin
					acc = (acc * c + 64'h8000_0000) >> 32;
				end
				c = (c * c + 64'h8000_0000) >> 32;
			end
			a = (acc + 64'h8000) >> 16;
			tbl[i] = (a > 64'(ALPHA_MAX)) ? ALPHA_BITS'(ALPHA_MAX) : a[ALPHA_BITS-1:0];
		end
		return tbl;
	endfunction

	localparam rom_t EXP_ROM = exp_rom_build();

	logic [ARG_BITS:0]   arg;
	logic                zero;
	logic [PROD_W-1:0]   prod;

	logic                zero_s16;
	logic [IDX_W-1:0]    idx_s16;
	logic [ALPHA_BITS-1:0] alpha_s17;

	assign arg  = {1'b0, res_x.term} + {1'b0, res_y.term};
	assign zero = res_x.over | res_y.over | arg[ARG_BITS];
	assign prod = PROD_W'(arg[ARG_BITS-1:0]) * PROD_W'(EXP_TABLE_DEPTH);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			zero_s16 <= zero;
			idx_s16  <= IDX_W'(prod >> ARG_BITS);
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			alpha_s17 <= zero_s16 ? '0 : EXP_ROM[idx_s16];
		end
	end

	assign alpha = alpha_s17;

endmodule

[src/gsp_blend_lane.sv]
module gsp_blend_lane import gsp_pkg::*; (
	input  logic                    clk,
	input  logic [BLEND_STAGES-1:0] en,
	input  logic [ALPHA_BITS-1:0]   alpha,
	input  logic [CH_BITS-1:0]      color,
	input  logic [CH_BITS-1:0]      base,
	output logic [CH_BITS-1:0]      result
);

	localparam int GW = CH_BITS + 2;
	localparam int PA_W = ALPHA_BITS + GW;
	localparam int PB_W = ALPHA_BITS + 1 + CH_BITS;
	localparam int SUM_W = PA_W + 1;
	localparam int SC_W = SUM_W - ALPHA_BITS;

	logic [GW-1:0]           gained;
	logic [ALPHA_BITS:0]     inv;
	logic [SUM_W-1:0]        sum;
	logic [SC_W-1:0]         scaled;

	logic [PA_W-1:0]         pa_s18;
	logic [PB_W-1:0]         pb_s18;
	logic [CH_BITS-1:0]      out_s19;

	assign gained = GW'(color) * GW'(GAIN);
	assign inv    = (ALPHA_BITS+1)'(ALPHA_ONE) - (ALPHA_BITS+1)'(alpha);

	always_ff @(posedge clk) begin
		if (en[0]) begin
			pa_s18 <= PA_W'(alpha) * PA_W'(gained);
			pb_s18 <= PB_W'(inv) * PB_W'(base);
		end
	end

	assign sum    = SUM_W'(pa_s18) + SUM_W'(pb_s18) + SUM_W'(ROUND_HALF);
	assign scaled = SC_W'(sum >> ALPHA_BITS);

	always_ff @(posedge clk) begin
		if (en[1]) begin
			out_s19 <= (scaled > SC_W'(CH_MAX)) ? CH_BITS'(CH_MAX) : scaled[CH_BITS-1:0];
		end
	end

	assign result = out_s19;

endmodule
